// ===== sv/rlc_pkg.sv =====
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared constants, codes and types of the RGBA layer compositor.
// ----------------------------------------------------------------------------
package rlc_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int X_W        = $clog2(MAX_WIDTH);
   localparam int Y_W        = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = X_W + Y_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   localparam int PIX_W      = 32;
   localparam int CH_W       = 8;
   localparam int LANES      = PIX_W / CH_W;
   localparam int PROD_W     = 2 * CH_W;
   localparam int POS_W      = 12;
   localparam int DIM_W      = 9;
   localparam int CSR_IDX_W  = 2;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_BLEND = 2'd1;

   localparam logic [1:0] STAT_READ    = 2'd0;
   localparam logic [1:0] STAT_BLENDED = 2'd1;
   localparam logic [1:0] STAT_CLIPPED = 2'd2;
   localparam logic [1:0] STAT_CLEARED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } ram_wr_type;

endpackage

// ===== sv/rlc_frame_ram.sv =====
// ----------------------------------------------------------------------------
// rlc_frame_ram
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rlc_frame_ram (
   input  logic                          clock,
   input  rlc_pkg::ram_wr_type           wr,
   input  logic [rlc_pkg::ADDR_W-1:0]    rd_addr,
   output logic [rlc_pkg::PIX_W-1:0]     rd_data
);

   logic [rlc_pkg::PIX_W-1:0] mem [rlc_pkg::DEPTH];
   logic [rlc_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rlc_blend.sv =====
// ----------------------------------------------------------------------------
// rlc_blend
// Source-over mix of four 8-bit lanes: products are registered, then each
// lane sum is divided by 255 with round-down.
// ----------------------------------------------------------------------------
module rlc_blend (
   input  logic                      clock,
   input  logic                      load,
   input  logic [rlc_pkg::PIX_W-1:0] src,
   input  logic [rlc_pkg::PIX_W-1:0] dst,
   output logic [rlc_pkg::PIX_W-1:0] mix
);

   logic [rlc_pkg::PROD_W-1:0] src_prod_ff [rlc_pkg::LANES];
   logic [rlc_pkg::PROD_W-1:0] dst_prod_ff [rlc_pkg::LANES];
   logic [rlc_pkg::PROD_W-1:0] src_prod_in [rlc_pkg::LANES];
   logic [rlc_pkg::PROD_W-1:0] dst_prod_in [rlc_pkg::LANES];
   logic [rlc_pkg::CH_W-1:0]   alpha;
   logic [rlc_pkg::CH_W-1:0]   inv_alpha;

   assign alpha     = src[rlc_pkg::PIX_W-1 -: rlc_pkg::CH_W];
   assign inv_alpha = ~alpha;

   always_comb begin
      for (int k = 0; k < rlc_pkg::LANES; k++) begin
         src_prod_in[k] = rlc_pkg::PROD_W'(src[k*rlc_pkg::CH_W +: rlc_pkg::CH_W]) *
                          rlc_pkg::PROD_W'(alpha);
         dst_prod_in[k] = rlc_pkg::PROD_W'(dst[k*rlc_pkg::CH_W +: rlc_pkg::CH_W]) *
                          rlc_pkg::PROD_W'(inv_alpha);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < rlc_pkg::LANES; k++) begin
            src_prod_ff[k] <= src_prod_in[k];
            dst_prod_ff[k] <= dst_prod_in[k];
         end
      end
   end

   // The sum never exceeds 255*255, where (n + n/256 + 1)/256 equals n/255.
   always_comb begin
      logic [rlc_pkg::PROD_W:0] sum;
      logic [rlc_pkg::PROD_W:0] adj;
      for (int k = 0; k < rlc_pkg::LANES; k++) begin
         sum = {1'b0, src_prod_ff[k]} + {1'b0, dst_prod_ff[k]};
         adj = sum + (sum >> rlc_pkg::CH_W) + (rlc_pkg::PROD_W+1)'(1);
         mix[k*rlc_pkg::CH_W +: rlc_pkg::CH_W] = adj[rlc_pkg::CH_W +: rlc_pkg::CH_W];
      end
   end

endmodule

// ===== sv/rgba_layer_compositor_unit.sv =====
// ----------------------------------------------------------------------------
// rgba_layer_compositor_unit
// RGBA8888 frame store with clear, source-over pixel blend and pixel read.
// ----------------------------------------------------------------------------
// A blend or read item is accepted in the idle state, and the frame store is
// read at the accepting edge; the lane products are registered in the fetch
// state, and the divide and write-back happen in the mix state once the output
// register is free, when the result is loaded into it. The next item is accepted
// after that, even while that result waits to be taken, but no new item is taken
// before the last one is through. A clear item sweeps the single write port
// over all 65536 words, one word per cycle, and returns its result once the
// sweep is over and the output register is free. After reset the same sweep runs
// before the first item is accepted; configuration writes are taken at any time.
module rgba_layer_compositor_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [rlc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rlc_pkg::DIM_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [rlc_pkg::POS_W-1:0]        req_pos_x,
   input  logic [rlc_pkg::POS_W-1:0]        req_pos_y,
   input  logic [rlc_pkg::CH_W-1:0]         req_src_red,
   input  logic [rlc_pkg::CH_W-1:0]         req_src_green,
   input  logic [rlc_pkg::CH_W-1:0]         req_src_blue,
   input  logic [rlc_pkg::CH_W-1:0]         req_src_alpha,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [rlc_pkg::CH_W-1:0]         rsp_out_red,
   output logic [rlc_pkg::CH_W-1:0]         rsp_out_green,
   output logic [rlc_pkg::CH_W-1:0]         rsp_out_blue,
   output logic [rlc_pkg::CH_W-1:0]         rsp_out_alpha
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_FETCH    = 3'd1;
   localparam logic [2:0] S_MIX      = 3'd2;
   localparam logic [2:0] S_SWEEP    = 3'd3;
   localparam logic [2:0] S_CLR_DONE = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [rlc_pkg::ADDR_W-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic                          sweep_rsp_ff, sweep_rsp_in;
   logic [rlc_pkg::DIM_W-1:0]     width_ff, width_in;
   logic [rlc_pkg::DIM_W-1:0]     height_ff, height_in;

   logic [1:0]                    op_ff, op_in;
   logic                          clip_ff, clip_in;
   logic [rlc_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [rlc_pkg::PIX_W-1:0]     src_ff, src_in;
   logic [rlc_pkg::PIX_W-1:0]     dst_ff, dst_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [rlc_pkg::PIX_W-1:0]     rsp_word_ff, rsp_word_in;

   logic                          accept;
   logic                          out_free;
   logic                          rsp_load;
   logic [1:0]                    load_status;
   logic [rlc_pkg::PIX_W-1:0]     load_word;
   logic [rlc_pkg::DIM_W-1:0]     width_eff;
   logic [rlc_pkg::DIM_W-1:0]     height_eff;
   logic                          in_frame;
   logic                          alpha_nz;
   logic [rlc_pkg::ADDR_W-1:0]    rd_addr;
   logic [rlc_pkg::PIX_W-1:0]     rd_data;
   logic [rlc_pkg::PIX_W-1:0]     mix;
   rlc_pkg::ram_wr_type           ram_wr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign width_eff  = (width_ff > rlc_pkg::DIM_W'(rlc_pkg::MAX_WIDTH)) ?
                       rlc_pkg::DIM_W'(rlc_pkg::MAX_WIDTH) : width_ff;
   assign height_eff = (height_ff > rlc_pkg::DIM_W'(rlc_pkg::MAX_HEIGHT)) ?
                       rlc_pkg::DIM_W'(rlc_pkg::MAX_HEIGHT) : height_ff;
   assign in_frame   = (req_pos_x < rlc_pkg::POS_W'(width_eff)) &&
                       (req_pos_y < rlc_pkg::POS_W'(height_eff));
   assign rd_addr    = {req_pos_y[rlc_pkg::Y_W-1:0], req_pos_x[rlc_pkg::X_W-1:0]};
   assign alpha_nz   = (src_ff[rlc_pkg::PIX_W-1 -: rlc_pkg::CH_W] != '0);

   rlc_frame_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rlc_blend u_blend (
      .clock (clock),
      .load  (state_ff == S_FETCH),
      .src   (src_ff),
      .dst   (rd_data),
      .mix   (mix)
   );

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         if (csr_index == rlc_pkg::CSR_FRAME_WIDTH) begin
            width_in = csr_wdata;
         end
         if (csr_index == rlc_pkg::CSR_FRAME_HEIGHT) begin
            height_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      sweep_rsp_in = sweep_rsp_ff;
      op_in        = op_ff;
      clip_in      = clip_ff;
      addr_in      = addr_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rsp_load     = 1'b0;
      load_status  = rlc_pkg::STAT_READ;
      load_word    = '0;
      ram_wr.we    = 1'b0;
      ram_wr.addr  = addr_ff;
      ram_wr.wdata = mix;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_type;
               clip_in = !in_frame;
               addr_in = rd_addr;
               src_in  = {req_src_alpha, req_src_blue, req_src_green, req_src_red};
               if (req_type == rlc_pkg::REQ_CLEAR) begin
                  state_in     = S_SWEEP;
                  sweep_cnt_in = '0;
                  sweep_rsp_in = 1'b1;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            dst_in   = rd_data;
            state_in = S_MIX;
         end
         S_MIX: begin
            if (clip_ff) begin
               load_status = rlc_pkg::STAT_CLIPPED;
               load_word   = '0;
            end else if (op_ff == rlc_pkg::REQ_BLEND) begin
               load_status = rlc_pkg::STAT_BLENDED;
               load_word   = alpha_nz ? mix : dst_ff;
            end else begin
               load_status = rlc_pkg::STAT_READ;
               load_word   = dst_ff;
            end
            if (out_free) begin
               rsp_load  = 1'b1;
               ram_wr.we = !clip_ff && (op_ff == rlc_pkg::REQ_BLEND) && alpha_nz;
               state_in  = S_IDLE;
            end
         end
         S_SWEEP: begin
            ram_wr.we    = 1'b1;
            ram_wr.addr  = sweep_cnt_ff;
            ram_wr.wdata = '0;
            sweep_cnt_in = sweep_cnt_ff + rlc_pkg::ADDR_W'(1);
            if (sweep_cnt_ff == '1) begin
               state_in = sweep_rsp_ff ? S_CLR_DONE : S_IDLE;
            end
         end
         S_CLR_DONE: begin
            load_status = rlc_pkg::STAT_CLEARED;
            load_word   = '0;
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = load_status;
         rsp_word_in   = load_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_cnt_ff <= '0;
         sweep_rsp_ff <= 1'b0;
         width_ff     <= rlc_pkg::DIM_W'(rlc_pkg::MAX_WIDTH);
         height_ff    <= rlc_pkg::DIM_W'(rlc_pkg::MAX_HEIGHT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         sweep_rsp_ff <= sweep_rsp_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      clip_ff       <= clip_in;
      addr_ff       <= addr_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_red   = rsp_word_ff[0*rlc_pkg::CH_W +: rlc_pkg::CH_W];
   assign rsp_out_green = rsp_word_ff[1*rlc_pkg::CH_W +: rlc_pkg::CH_W];
   assign rsp_out_blue  = rsp_word_ff[2*rlc_pkg::CH_W +: rlc_pkg::CH_W];
   assign rsp_out_alpha = rsp_word_ff[3*rlc_pkg::CH_W +: rlc_pkg::CH_W];

   // The store is written only by the sweep or by the write-back of a blend.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_wr.we |-> (state_ff == S_SWEEP || state_ff == S_MIX))
      else $error("frame store written outside sweep or write-back");

   // A write-back happens only for an in-frame blend with nonzero alpha.
   a_blend_write: assert property (@(posedge clock) disable iff (reset)
      (ram_wr.we && state_ff == S_MIX) |->
         (!clip_ff && op_ff == rlc_pkg::REQ_BLEND && alpha_nz))
      else $error("write-back for an item that must leave the store unchanged");

   // The sweep visits consecutive words without skipping.
   a_sweep_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && state_ff == S_SWEEP && $past(state_ff) == S_SWEEP) |->
         (sweep_cnt_ff == $past(sweep_cnt_ff) + rlc_pkg::ADDR_W'(1)))
      else $error("sweep counter did not advance by one");

   // A cleared result is reported only after a sweep has finished.
   a_clear_after_sweep: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && load_status == rlc_pkg::STAT_CLEARED) |->
         ($past(state_ff) == S_SWEEP || $past(state_ff) == S_CLR_DONE))
      else $error("clear result without a completed sweep");

endmodule
